// ===== hdl/qvt_pkg.sv =====
// qvt_pkg: shared types and constants of the quaternion vertex transform.
// Holds the register map, the configuration struct and the matrix type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qvt_pkg;

    // register field widths
    localparam int SCALE_W    = 16;
    localparam int QUAT_W     = 16;
    localparam int OFF_W      = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // quaternion products and matrix entries
    localparam int QPROD_W   = 2 * QUAT_W;   // q*q, frac 28
    localparam int M28_W     = QPROD_W + 2;  // 2*(a+b) or one-2*(a+b)
    localparam int MAT_DROP  = 12;           // frac 28 -> frac 16
    localparam int MAT_W     = M28_W - MAT_DROP;

    localparam logic [SCALE_W-1:0]       SCALE_RESET = 16'd256;
    localparam logic signed [QUAT_W-1:0] QUAT_ONE    = 16'sd16384;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE    = 3'd0,
        REG_QUAT_X   = 3'd1,
        REG_QUAT_Y   = 3'd2,
        REG_QUAT_Z   = 3'd3,
        REG_QUAT_W   = 3'd4,
        REG_OFFSET_X = 3'd5,
        REG_OFFSET_Y = 3'd6,
        REG_OFFSET_Z = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [SCALE_W-1:0]       scale;
        logic signed [QUAT_W-1:0] qx;
        logic signed [QUAT_W-1:0] qy;
        logic signed [QUAT_W-1:0] qz;
        logic signed [QUAT_W-1:0] qw;
        logic [OFF_W-1:0]         off_x;
        logic [OFF_W-1:0]         off_y;
        logic [OFF_W-1:0]         off_z;
    } cfg_t;

    // rotation matrix, Q.16, entry (r,c) at index r*3+c
    typedef logic signed [MAT_W-1:0] mat_elem_t;
    typedef mat_elem_t [8:0] mat_t;

endpackage

`default_nettype wire

// ===== hdl/qvt_cfg_regs.sv =====
// qvt_cfg_regs: configuration register file with plain write port.
// Depends on qvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qvt_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [qvt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [qvt_pkg::CFG_DATA_W-1:0] cfg_data,
    output qvt_pkg::cfg_t                       cfg
);
    import qvt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_SCALE:    cfg_next.scale = cfg_data[SCALE_W-1:0];
                REG_QUAT_X:   cfg_next.qx    = $signed(cfg_data[QUAT_W-1:0]);
                REG_QUAT_Y:   cfg_next.qy    = $signed(cfg_data[QUAT_W-1:0]);
                REG_QUAT_Z:   cfg_next.qz    = $signed(cfg_data[QUAT_W-1:0]);
                REG_QUAT_W:   cfg_next.qw    = $signed(cfg_data[QUAT_W-1:0]);
                REG_OFFSET_X: cfg_next.off_x = cfg_data[OFF_W-1:0];
                REG_OFFSET_Y: cfg_next.off_y = cfg_data[OFF_W-1:0];
                REG_OFFSET_Z: cfg_next.off_z = cfg_data[OFF_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // identity transform after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale <= SCALE_RESET;
            cfg_reg.qx    <= '0;
            cfg_reg.qy    <= '0;
            cfg_reg.qz    <= '0;
            cfg_reg.qw    <= QUAT_ONE;
            cfg_reg.off_x <= '0;
            cfg_reg.off_y <= '0;
            cfg_reg.off_z <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/qvt_matrix.sv =====
// qvt_matrix: two-stage pipeline that builds the rotation matrix from the
// quaternion registers. Depends on qvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qvt_matrix (
    input  wire logic  clk,
    input  wire qvt_pkg::cfg_t cfg,
    output qvt_pkg::mat_t mat
);
    import qvt_pkg::*;

    localparam logic signed [M28_W-1:0] ONE28 = M28_W'(64'sd1 <<< 28);

    // round half up from frac 28 to frac 16
    function automatic mat_elem_t round_m(input logic signed [M28_W-1:0] v);
        logic signed [M28_W-1:0] t;
        t = v + M28_W'(64'sd1 <<< (MAT_DROP - 1));
        return t[M28_W-1:MAT_DROP];
    endfunction

    logic signed [QPROD_W-1:0] xx_reg, yy_reg, zz_reg;
    logic signed [QPROD_W-1:0] xy_reg, xz_reg, yz_reg;
    logic signed [QPROD_W-1:0] wx_reg, wy_reg, wz_reg;
    logic signed [M28_W-1:0]   xx, yy, zz, xy, xz, yz, wx, wy, wz;
    mat_t                      mat_next;
    mat_t                      mat_reg;

    // stage A: component products
    always_ff @(posedge clk)
    begin
        xx_reg <= cfg.qx * cfg.qx;
        yy_reg <= cfg.qy * cfg.qy;
        zz_reg <= cfg.qz * cfg.qz;
        xy_reg <= cfg.qx * cfg.qy;
        xz_reg <= cfg.qx * cfg.qz;
        yz_reg <= cfg.qy * cfg.qz;
        wx_reg <= cfg.qw * cfg.qx;
        wy_reg <= cfg.qw * cfg.qy;
        wz_reg <= cfg.qw * cfg.qz;
    end

    // stage B: combine and round the nine entries
    always_comb
    begin
        xx = M28_W'(xx_reg);
        yy = M28_W'(yy_reg);
        zz = M28_W'(zz_reg);
        xy = M28_W'(xy_reg);
        xz = M28_W'(xz_reg);
        yz = M28_W'(yz_reg);
        wx = M28_W'(wx_reg);
        wy = M28_W'(wy_reg);
        wz = M28_W'(wz_reg);
        mat_next[0] = round_m(ONE28 - ((yy + zz) <<< 1));
        mat_next[1] = round_m((xy - wz) <<< 1);
        mat_next[2] = round_m((xz + wy) <<< 1);
        mat_next[3] = round_m((xy + wz) <<< 1);
        mat_next[4] = round_m(ONE28 - ((xx + zz) <<< 1));
        mat_next[5] = round_m((yz - wx) <<< 1);
        mat_next[6] = round_m((xz - wy) <<< 1);
        mat_next[7] = round_m((yz + wx) <<< 1);
        mat_next[8] = round_m(ONE28 - ((xx + yy) <<< 1));
    end

    always_ff @(posedge clk)
    begin
        mat_reg <= mat_next;
    end

    assign mat = mat_reg;

endmodule

`default_nettype wire

// ===== hdl/qvt_datapath.sv =====
// qvt_datapath: five-stage vertex pipeline: scale, round and split,
// matrix products, row sums, offset and saturation. Depends on qvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qvt_datapath #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic signed [COORD_WIDTH-1:0] in_x,
    input  wire logic signed [COORD_WIDTH-1:0] in_y,
    input  wire logic signed [COORD_WIDTH-1:0] in_z,
    input  wire qvt_pkg::cfg_t                 cfg,
    input  wire qvt_pkg::mat_t                 mat,
    output logic signed [COORD_WIDTH-1:0]      out_x,
    output logic signed [COORD_WIDTH-1:0]      out_y,
    output logic signed [COORD_WIDTH-1:0]      out_z,
    output logic                               done
);
    import qvt_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int PW  = CW + SCALE_W + 1;   // v*scale, frac 24
    localparam int SW  = PW - 8;             // scaled vertex, frac 16
    localparam int HW  = SW - 16;            // integer part
    localparam int LW  = 17;                 // fraction, zero-extended
    localparam int HPW = HW + MAT_W;
    localparam int LPW = LW + MAT_W;
    localparam int AHW = HPW + 2;
    localparam int ALW = LPW + 2;
    localparam int RLW = ALW - 16;
    localparam int RW  = AHW + 1;
    localparam int FW  = RW + 1;

    logic [4:0] valid_reg;

    logic signed [PW-1:0]  prod_reg [3];
    logic signed [HW-1:0]  hi_reg   [3];
    logic [15:0]           lo_reg   [3];
    logic signed [HPW-1:0] hp_reg   [9];
    logic signed [LPW-1:0] lp_reg   [9];
    logic signed [AHW-1:0] acc_hi_reg [3];
    logic signed [RLW-1:0] lo_rnd_reg [3];
    logic signed [CW-1:0]  out_reg  [3];

    logic signed [CW-1:0]  vin      [3];
    logic signed [PW-1:0]  rnd_tmp  [3];
    logic signed [HPW-1:0] hp_next  [9];
    logic signed [LPW-1:0] lp_next  [9];
    logic signed [AHW-1:0] acc_hi_next [3];
    logic signed [ALW-1:0] acc_lo   [3];
    logic signed [RLW-1:0] lo_rnd_next [3];
    logic [OFF_W-1:0]      off_raw  [3];
    logic signed [CW-1:0]  off_c    [3];
    logic signed [FW-1:0]  sum      [3];
    logic signed [CW-1:0]  out_next [3];

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[3:0], in_valid};
    end

    // stage 1: scale
    assign vin[0] = in_x;
    assign vin[1] = in_y;
    assign vin[2] = in_z;

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
            prod_reg[c] <= PW'(vin[c]) * PW'($signed({1'b0, cfg.scale}));
    end

    // stage 2: round to frac 16, split integer and fraction
    always_comb
    begin
        for (int c = 0; c < 3; c++)
            rnd_tmp[c] = prod_reg[c] + PW'(128);
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            hi_reg[c] <= rnd_tmp[c][PW-1:24];
            lo_reg[c] <= rnd_tmp[c][23:8];
        end
    end

    // stage 3: partial products with the matrix
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            hp_next[i] = HPW'(hi_reg[i % 3]) * HPW'($signed(mat[i]));
            lp_next[i] = LPW'($signed({1'b0, lo_reg[i % 3]})) * LPW'($signed(mat[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            hp_reg[i] <= hp_next[i];
            lp_reg[i] <= lp_next[i];
        end
    end

    // stage 4: row sums, fraction sum rounded to frac 16
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc_hi_next[r] = AHW'(hp_reg[3*r]) + AHW'(hp_reg[3*r+1]) + AHW'(hp_reg[3*r+2]);
            acc_lo[r] = ALW'(lp_reg[3*r]) + ALW'(lp_reg[3*r+1]) + ALW'(lp_reg[3*r+2])
                      + ALW'(32768);
            lo_rnd_next[r] = acc_lo[r][ALW-1:16];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc_hi_reg[r] <= acc_hi_next[r];
            lo_rnd_reg[r] <= lo_rnd_next[r];
        end
    end

    // offsets read at coordinate width
    assign off_raw[0] = cfg.off_x;
    assign off_raw[1] = cfg.off_y;
    assign off_raw[2] = cfg.off_z;

    generate
        if (CW >= OFF_W)
        begin : g_off_wide
            for (genvar r = 0; r < 3; r++)
            begin : g_row
                assign off_c[r] = CW'(off_raw[r]);
            end
        end
        else
        begin : g_off_narrow
            for (genvar r = 0; r < 3; r++)
            begin : g_row
                assign off_c[r] = $signed(off_raw[r][CW-1:0]);
            end
        end
    endgenerate

    // stage 5: add offset, saturate to coordinate width
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum[r] = FW'(acc_hi_reg[r]) + FW'(lo_rnd_reg[r]) + FW'(off_c[r]);
            if ((&sum[r][FW-1:CW-1]) || !(|sum[r][FW-1:CW-1]))
                out_next[r] = sum[r][CW-1:0];
            else if (sum[r][FW-1])
                out_next[r] = {1'b1, {(CW-1){1'b0}}};
            else
                out_next[r] = {1'b0, {(CW-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
            out_reg[r] <= out_next[r];
    end

    assign out_x = out_reg[0];
    assign out_y = out_reg[1];
    assign out_z = out_reg[2];
    assign done  = valid_reg[4];

endmodule

`default_nettype wire

// ===== hdl/quaternion_vertex_transform_unit.sv =====
// Quaternion vertex transform: scale, rotate by quaternion matrix, translate.
// Result strobed on done after the scale, round, product, sum and output regs.
// Throughput: one vertex per cycle; busy stays low, the receiver cannot stall.
// Matrix is rebuilt in registers after a quaternion write, before a vertex
// accepted next needs it. Reset (rst_n, async) loads identity config, clears valids.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_vertex_transform_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic signed [COORD_WIDTH-1:0]  in_x,
    input  wire logic signed [COORD_WIDTH-1:0]  in_y,
    input  wire logic signed [COORD_WIDTH-1:0]  in_z,
    output logic                                done,
    output logic signed [COORD_WIDTH-1:0]       out_x,
    output logic signed [COORD_WIDTH-1:0]       out_y,
    output logic signed [COORD_WIDTH-1:0]       out_z,
    input  wire logic                           cfg_write,
    input  wire logic [qvt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [qvt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import qvt_pkg::*;

    cfg_t cfg;
    mat_t mat;
    logic accept;

    // fully pipelined, a request is taken every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    qvt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    qvt_matrix u_matrix (
        .clk (clk),
        .cfg (cfg),
        .mat (mat)
    );

    qvt_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .in_x     (in_x),
        .in_y     (in_y),
        .in_z     (in_z),
        .cfg      (cfg),
        .mat      (mat),
        .out_x    (out_x),
        .out_y    (out_y),
        .out_z    (out_z),
        .done     (done)
    );

endmodule

`default_nettype wire
